// ===== sv/per_pkg.sv =====
// Package for the particle ellipsoid radii block: field widths, stream packing,
// configuration register indexes and a saturation helper.
// No dependencies.
package per_pkg;

  localparam int unsigned RAD_W  = 31;   // Q15.16 radii and factors
  localparam int unsigned VEL_W  = 24;   // signed velocity component
  localparam int unsigned AXIS_W = 18;   // signed Q1.F axis component

  localparam int unsigned IN_TDATA_W  = 104;
  localparam int unsigned OUT_TDATA_W = 120;

  localparam logic [RAD_W-1:0] MAX31 = '1;

  // Widths inside the iterative units
  localparam int unsigned S2_W    = 48;  // squared speed, raw
  localparam int unsigned SPD_W   = 24;  // speed root
  localparam int unsigned CUBE_W  = 93;  // r^3
  localparam int unsigned CQ_W    = 62;  // floor(r^3 / major)

  typedef enum logic [1:0] {
    REG_RADIUS_SCALE = 2'd0,
    REG_TIME_STEP    = 2'd1,
    REG_VEL_SCALING  = 2'd2,
    REG_KEEP_VOLUME  = 2'd3
  } cfg_idx_t;

  function automatic logic [RAD_W-1:0] sat31(input logic [63:0] v);
    logic [RAD_W-1:0] res;
    res = (v > 64'(MAX31)) ? MAX31 : v[RAD_W-1:0];
    return res;
  endfunction

endpackage

// ===== sv/particle_ellipsoid_radii.sv =====
// Particle ellipsoid radii: pipelined radius scaling, speed square root, axis
// normalization, velocity stretch and volume keeping minor radius.
// Depends on per_pkg.
//
// The pipeline depth is independent of FRAC_BITS. Throughput: one item per
// cycle while out_ is not stalled; the longest chain is the 62 step restoring
// divider for r^3/major followed by the 31 step square root, one quotient or
// root bit per stage. Backpressure on out_ freezes the whole pipeline.
// Reset (rst_n low, synchronous) clears all valid bits and loads the register
// defaults: radius_scale = 1.0, time_step = 0, both mode bits off.
module particle_ellipsoid_radii
  import per_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata: particle_radius[30:0], vel_x[54:31], vel_y[78:55], vel_z[102:79]
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // out_tdata: major_radius[30:0], minor_radius[61:31], axis_x[79:62],
  //            axis_y[97:80], axis_z[115:98]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [RAD_W-1:0]       cfg_wdata
);

  // ---------------------------------------------------------------------------
  // Stage map (pipeline register index of each step)
  //   1      products: radius*scale, velocity squares, |v|
  //   2      scaled radius r, squared speed s2
  //   3..26  speed = isqrt(s2), one root bit per stage; slow flag at 3
  //   27     time_step*speed, r*r; axis dividers start (FRAC_BITS+1 stages)
  //   28     major radius, partial products of r^3
  //   29     r^3
  //   30..91 floor(r^3/major), one quotient bit per stage
  //   92..122 isqrt of that quotient, one root bit per stage
  //   123    output register
  // ---------------------------------------------------------------------------
  localparam int unsigned SA_N     = SPD_W;            // speed sqrt steps
  localparam int unsigned AX_N     = FRAC_BITS + 1;    // axis quotient bits
  localparam int unsigned CD_N     = CQ_W;             // cube divide steps
  localparam int unsigned SB_N     = CQ_W / 2;         // minor sqrt steps
  localparam int unsigned ST_SPD   = 2 + SA_N;
  localparam int unsigned ST_MUL   = ST_SPD + 1;
  localparam int unsigned ST_MAJ   = ST_MUL + 1;
  localparam int unsigned ST_CUBE  = ST_MAJ + 1;
  localparam int unsigned ST_CDE   = ST_CUBE + CD_N;
  localparam int unsigned ST_END   = ST_CDE + SB_N;
  localparam int unsigned ST_OUT   = ST_END + 1;
  localparam int unsigned ST_AXQ   = ST_SPD + AX_N;    // axis quotient ready
  localparam int unsigned ST_QC    = ST_AXQ + 1;       // first carry slot

  localparam logic [RAD_W-1:0]  RS_RESET = RAD_W'(64'd1 << FRAC_BITS);
  localparam logic [S2_W-1:0]   SPD_THR  = S2_W'((64'd1 << (2 * FRAC_BITS)) / 64'd100000000);
  localparam logic [AXIS_W-1:0] AX_ONE   = AXIS_W'(64'd1 << FRAC_BITS);
  localparam logic [AXIS_W-1:0] AX_POS   = 18'h1FFFF;
  localparam logic [AXIS_W-1:0] AX_NEG   = 18'h20000;

  // Configuration registers
  logic [RAD_W-1:0] radius_scale_r;
  logic [RAD_W-1:0] time_step_r;
  logic             vel_scaling_r;
  logic             keep_volume_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_scale_r <= RS_RESET;
      time_step_r    <= '0;
      vel_scaling_r  <= 1'b0;
      keep_volume_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_RADIUS_SCALE: radius_scale_r <= cfg_wdata;
        REG_TIME_STEP:    time_step_r    <= cfg_wdata;
        REG_VEL_SCALING:  vel_scaling_r  <= cfg_wdata[0];
        REG_KEEP_VOLUME:  keep_volume_r  <= cfg_wdata[0];
      endcase
    end
  end

  // Global pipeline advance: everything moves unless the result is stuck
  logic en;
  logic vld_r [1:ST_OUT];

  assign en         = !vld_r[ST_OUT] || out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[ST_OUT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 1; s <= ST_OUT; s++) vld_r[s] <= 1'b0;
    end else if (en) begin
      vld_r[1] <= in_tvalid;
      for (int s = 2; s <= ST_OUT; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  // Input unpack
  logic        [RAD_W-1:0] in_prad;
  logic signed [VEL_W-1:0] in_vel [3];
  logic        [VEL_W-1:0] in_abs [3];

  assign in_prad   = in_tdata[30:0];
  assign in_vel[0] = in_tdata[54:31];
  assign in_vel[1] = in_tdata[78:55];
  assign in_vel[2] = in_tdata[102:79];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_abs[i] = in_vel[i][VEL_W-1] ? VEL_W'(-in_vel[i]) : VEL_W'(in_vel[i]);
    end
  end

  // Front stages and carried values
  logic [61:0]       s1_prod_r;
  logic [S2_W-1:0]   s1_sq_r [3];
  logic [S2_W-1:0]   s2_sum_r;
  logic [VEL_W-1:0]  absv_st_r [1:ST_SPD][3];
  logic [2:0]        sgn_st_r  [1:ST_END];
  logic [RAD_W-1:0]  r_st_r    [2:ST_END];
  logic              slow_st_r [3:ST_END];
  logic [SPD_W-1:0]  spd_st_r  [ST_MUL:ST_SPD+FRAC_BITS];
  logic [FRAC_BITS:0] q_st_r   [ST_QC:ST_END][3];
  logic [54:0]       mul_ts_r;
  logic [61:0]       rr_r;
  logic [61:0]       chi_r;
  logic [61:0]       clo_r;
  logic [CUBE_W-1:0] cube_r;
  logic [RAD_W-1:0]  major_st_r [ST_MAJ:ST_END];
  logic [55:0]       maj_sum;

  assign maj_sum = 56'(r_st_r[ST_MUL]) + 56'(mul_ts_r >> (FRAC_BITS + 1));

  // Iterative unit registers
  logic [S2_W-1:0]   sa_rad_r  [SA_N];
  logic [25:0]       sa_rem_r  [SA_N];
  logic [SPD_W-1:0]  sa_root_r [SA_N];
  logic [S2_W-1:0]   sa_rad_nxt  [SA_N];
  logic [25:0]       sa_rem_nxt  [SA_N];
  logic [SPD_W-1:0]  sa_root_nxt [SA_N];

  logic [SPD_W-1:0]   ad_rem_r   [3][AX_N];
  logic [FRAC_BITS:0] ad_q_r     [3][AX_N];
  logic [SPD_W-1:0]   ad_rem_nxt [3][AX_N];
  logic [FRAC_BITS:0] ad_q_nxt   [3][AX_N];

  logic [RAD_W-1:0]  cd_rem_r   [CD_N];
  logic [CQ_W-1:0]   cd_dvd_r   [CD_N];
  logic [CQ_W-1:0]   cd_q_r     [CD_N];
  logic [RAD_W-1:0]  cd_rem_nxt [CD_N];
  logic [CQ_W-1:0]   cd_dvd_nxt [CD_N];
  logic [CQ_W-1:0]   cd_q_nxt   [CD_N];

  logic [CQ_W-1:0]   sb_rad_r   [SB_N];
  logic [31:0]       sb_rem_r   [SB_N];
  logic [RAD_W-1:0]  sb_root_r  [SB_N];
  logic [CQ_W-1:0]   sb_rad_nxt [SB_N];
  logic [31:0]       sb_rem_nxt [SB_N];
  logic [RAD_W-1:0]  sb_root_nxt[SB_N];

  // Speed square root: restoring, one root bit per stage
  for (genvar k = 0; k < SA_N; k++) begin : g_sa
    logic [S2_W-1:0]  rad_in;
    logic [25:0]      rem_in;
    logic [SPD_W-1:0] root_in;
    logic [27:0]      rem2;
    logic [27:0]      trial;
    logic             ge;
    if (k == 0) begin : g_first
      assign rad_in  = s2_sum_r;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = sa_rad_r[k-1];
      assign rem_in  = sa_rem_r[k-1];
      assign root_in = sa_root_r[k-1];
    end
    always_comb begin
      rem2           = {rem_in, rad_in[S2_W-1 -: 2]};
      trial          = {2'b00, root_in, 2'b01};
      ge             = rem2 >= trial;
      sa_rem_nxt[k]  = ge ? 26'(rem2 - trial) : 26'(rem2);
      sa_root_nxt[k] = {root_in[SPD_W-2:0], ge};
      sa_rad_nxt[k]  = {rad_in[S2_W-3:0], 2'b00};
    end
  end

  // Axis dividers: |v|*2^F / speed, quotient < 2^(F+1) since |v| <= speed
  for (genvar i = 0; i < 3; i++) begin : g_ax
    for (genvar j = 0; j < AX_N; j++) begin : g_step
      logic [SPD_W:0]     rem_in;
      logic [SPD_W-1:0]   spd;
      logic [FRAC_BITS:0] q_in;
      logic               ge;
      if (j == 0) begin : g_first
        assign rem_in = {1'b0, absv_st_r[ST_SPD][i]};
        assign spd    = sa_root_r[SA_N-1];
        assign q_in   = '0;
      end else begin : g_next
        assign rem_in = {ad_rem_r[i][j-1], 1'b0};
        assign spd    = spd_st_r[ST_SPD+j];
        assign q_in   = ad_q_r[i][j-1];
      end
      always_comb begin
        ge               = rem_in >= {1'b0, spd};
        ad_rem_nxt[i][j] = ge ? SPD_W'(rem_in - {1'b0, spd}) : SPD_W'(rem_in);
        ad_q_nxt[i][j]   = {q_in[FRAC_BITS-1:0], ge};
      end
    end
  end

  // floor(r^3 / major): initial partial remainder r^3 >> 62 is below major
  for (genvar j = 0; j < CD_N; j++) begin : g_cd
    logic [RAD_W-1:0] rem_in;
    logic [CQ_W-1:0]  dvd_in;
    logic [CQ_W-1:0]  q_in;
    logic [RAD_W:0]   rem2;
    logic             ge;
    if (j == 0) begin : g_first
      assign rem_in = cube_r[CUBE_W-1:CQ_W];
      assign dvd_in = cube_r[CQ_W-1:0];
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = cd_rem_r[j-1];
      assign dvd_in = cd_dvd_r[j-1];
      assign q_in   = cd_q_r[j-1];
    end
    always_comb begin
      rem2          = {rem_in, dvd_in[CQ_W-1]};
      ge            = rem2 >= {1'b0, major_st_r[ST_CUBE+j]};
      cd_rem_nxt[j] = ge ? RAD_W'(rem2 - {1'b0, major_st_r[ST_CUBE+j]}) : RAD_W'(rem2);
      cd_dvd_nxt[j] = {dvd_in[CQ_W-2:0], 1'b0};
      cd_q_nxt[j]   = {q_in[CQ_W-2:0], ge};
    end
  end

  // Minor radius square root
  for (genvar k = 0; k < SB_N; k++) begin : g_sb
    logic [CQ_W-1:0]  rad_in;
    logic [31:0]      rem_in;
    logic [RAD_W-1:0] root_in;
    logic [33:0]      rem2;
    logic [33:0]      trial;
    logic             ge;
    if (k == 0) begin : g_first
      assign rad_in  = cd_q_r[CD_N-1];
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = sb_rad_r[k-1];
      assign rem_in  = sb_rem_r[k-1];
      assign root_in = sb_root_r[k-1];
    end
    always_comb begin
      rem2           = {rem_in, rad_in[CQ_W-1 -: 2]};
      trial          = {1'b0, root_in, 2'b01};
      ge             = rem2 >= trial;
      sb_rem_nxt[k]  = ge ? 32'(rem2 - trial) : 32'(rem2);
      sb_root_nxt[k] = {root_in[RAD_W-2:0], ge};
      sb_rad_nxt[k]  = {rad_in[CQ_W-3:0], 2'b00};
    end
  end

  // Output assembly from the last pipeline stage
  logic [RAD_W-1:0]  major_nxt;
  logic [RAD_W-1:0]  minor_nxt;
  logic [AXIS_W-1:0] axis_nxt [3];

  always_comb begin
    major_nxt = slow_st_r[ST_END] ? r_st_r[ST_END] : major_st_r[ST_END];
    if (slow_st_r[ST_END] || !vel_scaling_r || !keep_volume_r) begin
      minor_nxt = r_st_r[ST_END];
    end else if (major_st_r[ST_END] == '0) begin
      minor_nxt = '0;
    end else begin
      minor_nxt = sb_root_r[SB_N-1];
    end
    for (int i = 0; i < 3; i++) begin
      if (slow_st_r[ST_END]) begin
        axis_nxt[i] = (i == 0) ? AX_ONE : '0;
      end else if (sgn_st_r[ST_END][i]) begin
        axis_nxt[i] = (32'(q_st_r[ST_END][i]) > 32'(AX_NEG)) ? AX_NEG
                    : AXIS_W'(-AXIS_W'(q_st_r[ST_END][i]));
      end else begin
        axis_nxt[i] = (32'(q_st_r[ST_END][i]) > 32'(AX_POS)) ? AX_POS
                    : AXIS_W'(q_st_r[ST_END][i]);
      end
    end
  end

  // Payload registers
  logic [RAD_W-1:0]  out_major_r;
  logic [RAD_W-1:0]  out_minor_r;
  logic [AXIS_W-1:0] out_axis_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1
      s1_prod_r <= 62'(radius_scale_r) * 62'(in_prad);
      for (int i = 0; i < 3; i++) begin
        s1_sq_r[i]      <= S2_W'(in_vel[i] * in_vel[i]);
        absv_st_r[1][i] <= in_abs[i];
        sgn_st_r[1][i]  <= in_vel[i][VEL_W-1];
      end
      // stage 2
      r_st_r[2] <= sat31(64'(s1_prod_r >> FRAC_BITS));
      s2_sum_r  <= s1_sq_r[0] + s1_sq_r[1] + s1_sq_r[2];
      // stage 3
      slow_st_r[3] <= (s2_sum_r <= SPD_THR);
      // carried values
      for (int s = 2; s <= ST_SPD; s++) absv_st_r[s] <= absv_st_r[s-1];
      for (int s = 2; s <= ST_END; s++) sgn_st_r[s]  <= sgn_st_r[s-1];
      for (int s = 3; s <= ST_END; s++) r_st_r[s]    <= r_st_r[s-1];
      for (int s = 4; s <= ST_END; s++) slow_st_r[s] <= slow_st_r[s-1];
      spd_st_r[ST_MUL] <= sa_root_r[SA_N-1];
      for (int s = ST_MUL + 1; s <= ST_SPD + FRAC_BITS; s++) spd_st_r[s] <= spd_st_r[s-1];
      for (int i = 0; i < 3; i++) q_st_r[ST_QC][i] <= ad_q_r[i][AX_N-1];
      for (int s = ST_QC + 1; s <= ST_END; s++) q_st_r[s] <= q_st_r[s-1];
      // stretch and cube
      mul_ts_r <= 55'(time_step_r) * 55'(sa_root_r[SA_N-1]);
      rr_r     <= 62'(r_st_r[ST_SPD]) * 62'(r_st_r[ST_SPD]);
      major_st_r[ST_MAJ] <= vel_scaling_r ? sat31(64'(maj_sum))
                                          : sat31(64'(r_st_r[ST_MUL]) * 64'd3);
      chi_r  <= 62'(rr_r[61:31]) * 62'(r_st_r[ST_MUL]);
      clo_r  <= 62'(rr_r[30:0]) * 62'(r_st_r[ST_MUL]);
      cube_r <= {chi_r, 31'b0} + CUBE_W'(clo_r);
      for (int s = ST_MAJ + 1; s <= ST_END; s++) major_st_r[s] <= major_st_r[s-1];
      // iterative units
      for (int k = 0; k < SA_N; k++) begin
        sa_rad_r[k]  <= sa_rad_nxt[k];
        sa_rem_r[k]  <= sa_rem_nxt[k];
        sa_root_r[k] <= sa_root_nxt[k];
      end
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < AX_N; j++) begin
          ad_rem_r[i][j] <= ad_rem_nxt[i][j];
          ad_q_r[i][j]   <= ad_q_nxt[i][j];
        end
      end
      for (int j = 0; j < CD_N; j++) begin
        cd_rem_r[j] <= cd_rem_nxt[j];
        cd_dvd_r[j] <= cd_dvd_nxt[j];
        cd_q_r[j]   <= cd_q_nxt[j];
      end
      for (int k = 0; k < SB_N; k++) begin
        sb_rad_r[k]  <= sb_rad_nxt[k];
        sb_rem_r[k]  <= sb_rem_nxt[k];
        sb_root_r[k] <= sb_root_nxt[k];
      end
      // output register
      out_major_r <= major_nxt;
      out_minor_r <= minor_nxt;
      for (int i = 0; i < 3; i++) out_axis_r[i] <= axis_nxt[i];
    end
  end

  assign out_tdata = {4'b0, out_axis_r[2], out_axis_r[1], out_axis_r[0],
                      out_minor_r, out_major_r};

endmodule
